>>> design/altip_pkg.sv
package altip_pkg;

  localparam int unsigned MaxKnotsDefault = 1024;
  localparam int unsigned PosW = 32;
  localparam int unsigned SmpW = 32;
  localparam int unsigned CountW = 11;
  localparam int unsigned MarginW = 16;
  localparam int unsigned SlotW = 10;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgAddrW = 3;

  localparam logic [MarginW-1:0] MarginReset = 16'd4;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [StatusW-1:0] {
    ST_INTERP = 3'd0,
    ST_EXACT  = 3'd1,
    ST_LOW    = 3'd2,
    ST_HIGH   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  localparam logic [CfgAddrW-1:0] AddrKnotCount = 3'd0;
  localparam logic [CfgAddrW-1:0] AddrEdgeMargin = 3'd4;

  typedef struct packed {
    logic          start;
    logic [PosW:0] mag;
    logic [PosW:0] t;
    logic [PosW:0] d;
  } div_req_t;

endpackage

>>> design/altip_if.sv
interface altip_in_if;
  import altip_pkg::*;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [SlotW-1:0]    knot_slot;
  logic [PosW-1:0]     arc_position;
  logic signed [SmpW-1:0] sample_first;
  logic signed [SmpW-1:0] sample_second;
  modport source (output valid, opcode, knot_slot, arc_position, sample_first,
                  sample_second, input ready);
  modport sink (input valid, opcode, knot_slot, arc_position, sample_first,
                sample_second, output ready);
endinterface

interface altip_out_if;
  import altip_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [SmpW-1:0] value_first;
  logic signed [SmpW-1:0] value_second;
  logic [StatusW-1:0]     query_status;
  modport source (output valid, value_first, value_second, query_status, input ready);
  modport sink (input valid, value_first, value_second, query_status, output ready);
endinterface

>>> design/arc_length_table_interpolator_core.sv
// Channel | Dir | Payload
// in_     | in  | opcode, knot_slot, arc_position, sample_first, sample_second
// out_    | out | value_first, value_second, query_status
// cfg_    | in  | APB registers knot_count at 0x0, edge_margin at 0x4
//
// A knot write is accepted while idle. A query of a non-empty table reads the
// first and last knots and, unless it clamps low or high, runs a binary search
// with one memory read per step, reads the two bracketing knots, and then, when
// it interpolates, runs the serial multiply-divide twice, once per lane.
// Reset is synchronous and active low; the table contents are undefined until
// written. A finished result waits in the output register while out_ready is
// low, and the next transaction is taken only after it has left.
module arc_length_table_interpolator_core #(
  parameter int unsigned MAX_KNOTS = altip_pkg::MaxKnotsDefault
) (
  input  logic clk,
  input  logic rst_n,
  altip_in_if.sink    in_ch,
  altip_out_if.source out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [altip_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import altip_pkg::*;

  localparam int unsigned AW = $clog2(MAX_KNOTS);
  // Search bounds run from 0 to the knot count itself, so one more bit.
  localparam int unsigned IW = AW + 1;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RD0   = 11'b00000000010,
    S_RDN   = 11'b00000000100,
    S_CHK   = 11'b00000001000,
    S_SRD   = 11'b00000010000,
    S_SCMP  = 11'b00000100000,
    S_RDHI  = 11'b00001000000,
    S_RDLO  = 11'b00010000000,
    S_EVAL  = 11'b00100000000,
    S_DIV   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  // Configuration registers.
  logic [CountW-1:0]  knot_count_r;
  logic [MarginW-1:0] edge_margin_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r  <= '0;
      edge_margin_r <= MarginReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr)
        AddrKnotCount:  knot_count_r  <= cfg_pwdata[CountW-1:0];
        AddrEdgeMargin: edge_margin_r <= cfg_pwdata[MarginW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      AddrKnotCount:  cfg_prdata = 32'(knot_count_r);
      AddrEdgeMargin: cfg_prdata = 32'(edge_margin_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Saturated knot count.
  logic [IW-1:0] n_eff;
  always_comb begin
    if (32'(knot_count_r) > MAX_KNOTS) n_eff = IW'(MAX_KNOTS);
    else n_eff = IW'(knot_count_r);
  end

  state_t state_r;
  logic   mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [3*PosW-1:0] mem_wdata, mem_rdata;
  logic [PosW-1:0] rd_pos;
  logic [SmpW-1:0] rd_f, rd_s;

  assign rd_pos = mem_rdata[3*PosW-1:2*PosW];
  assign rd_f   = mem_rdata[2*PosW-1:PosW];
  assign rd_s   = mem_rdata[PosW-1:0];

  altip_mem #(.MAX_KNOTS(MAX_KNOTS), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  logic [PosW-1:0] s_r;
  logic [IW-1:0]   lo_r, hi_r, n_r;
  logic [PosW-1:0] p0_r, p1_r;
  logic [SmpW-1:0] f0_r, s0_r, f1_r, s1_r;
  logic [PosW-1:0] pfirst_r;
  logic [SmpW-1:0] ffirst_r, sfirst_r;
  logic            lane_r;
  logic [SmpW-1:0] res_f_r;
  logic [SmpW-1:0] res_s_r;
  logic [StatusW-1:0] status_r;
  logic [IW-1:0]   mid;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  // Write path: slots at or above the table depth are dropped.
  logic in_fire;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign mem_we = in_fire && (in_ch.opcode == OP_WRITE) &&
                  (32'(in_ch.knot_slot) < MAX_KNOTS);
  assign mem_waddr = AW'(in_ch.knot_slot);
  assign mem_wdata = {in_ch.arc_position, in_ch.sample_first, in_ch.sample_second};

  // Knot zero is read while idle, so its data is present in S_RD0. The last
  // knot is read in S_RD0 and held through S_RDN, so it is present in S_CHK.
  // The upper bracketing knot is read first, then the lower one.
  always_comb begin
    unique case (state_r)
      S_IDLE:  mem_raddr = '0;
      S_RD0:   mem_raddr = AW'(n_r - 1'b1);
      S_RDN:   mem_raddr = AW'(n_r - 1'b1);
      S_SRD:   mem_raddr = AW'(mid);
      S_RDHI:  mem_raddr = AW'(lo_r);
      S_RDLO:  mem_raddr = AW'(lo_r - 1'b1);
      default: mem_raddr = AW'(lo_r);
    endcase
  end

  // Interpolation per lane.
  logic signed [PosW:0] v0x, v1x, diff;
  logic          neg;
  logic [PosW:0] mag, tt, dd, qv;
  logic          div_done;
  div_req_t      dreq;
  logic signed [PosW:0] lerp;

  always_comb begin
    v0x  = lane_r ? {s0_r[SmpW-1], s0_r} : {f0_r[SmpW-1], f0_r};
    v1x  = lane_r ? {s1_r[SmpW-1], s1_r} : {f1_r[SmpW-1], f1_r};
    diff = v1x - v0x;
    neg  = diff[PosW];
    mag  = neg ? -diff : diff;
    dd   = {1'b0, p1_r - p0_r};
    tt   = {1'b0, s_r - p0_r};
    if (tt > dd) tt = dd;
    lerp = neg ? v0x - $signed(qv) : v0x + $signed(qv);
  end

  logic start_r;
  assign dreq.start = start_r;
  assign dreq.mag = mag;
  assign dreq.t = tt;
  assign dreq.d = dd;

  altip_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(div_done), .quot(qv));

  logic [PosW:0] s_plus, last_plus;
  assign s_plus    = {1'b0, s_r} + {{(PosW+1-MarginW){1'b0}}, edge_margin_r};
  assign last_plus = {1'b0, rd_pos} + {{(PosW+1-MarginW){1'b0}}, edge_margin_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && in_ch.opcode == OP_QUERY) begin
            s_r <= in_ch.arc_position;
            n_r <= n_eff;
            if (n_eff == '0) begin
              res_f_r  <= '0;
              res_s_r  <= '0;
              status_r <= ST_EMPTY;
              state_r  <= S_OUT;
            end else begin
              state_r <= S_RD0;
            end
          end
        end
        S_RD0: begin
          // Knot zero data arrives now; the last knot read is issued.
          pfirst_r <= rd_pos;
          ffirst_r <= rd_f;
          sfirst_r <= rd_s;
          state_r  <= S_RDN;
        end
        S_RDN: state_r <= S_CHK;
        S_CHK: begin
          lo_r <= '0;
          hi_r <= n_r;
          if (s_plus < {1'b0, pfirst_r}) begin
            res_f_r  <= ffirst_r;
            res_s_r  <= sfirst_r;
            status_r <= ST_LOW;
            state_r  <= S_OUT;
          end else if ({1'b0, s_r} > last_plus) begin
            res_f_r  <= rd_f;
            res_s_r  <= rd_s;
            status_r <= ST_HIGH;
            state_r  <= S_OUT;
          end else begin
            // Just above the last knot within the margin clamps high as well.
            res_f_r <= rd_f;
            res_s_r <= rd_s;
            state_r <= S_SRD;
          end
        end
        S_SRD: begin
          if (lo_r < hi_r) state_r <= S_SCMP;
          else if (lo_r >= n_r) begin
            status_r <= ST_HIGH;
            state_r  <= S_OUT;
          end else state_r <= S_RDHI;
        end
        S_SCMP: begin
          if (rd_pos < s_r) lo_r <= mid + 1'b1;
          else hi_r <= mid;
          state_r <= S_SRD;
        end
        S_RDHI: state_r <= S_RDLO;
        S_RDLO: begin
          p1_r <= rd_pos;
          f1_r <= rd_f;
          s1_r <= rd_s;
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          p0_r <= rd_pos;
          f0_r <= rd_f;
          s0_r <= rd_s;
          if (lo_r == '0 || p1_r == s_r) begin
            res_f_r  <= f1_r;
            res_s_r  <= s1_r;
            status_r <= ST_EXACT;
            state_r  <= S_OUT;
          end else begin
            status_r <= ST_INTERP;
            if (p1_r <= rd_pos || s_r <= rd_pos) begin
              res_f_r <= rd_f;
              res_s_r <= rd_s;
              state_r <= S_OUT;
            end else begin
              lane_r  <= 1'b0;
              start_r <= 1'b1;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (!lane_r) begin
              res_f_r <= lerp[SmpW-1:0];
              lane_r  <= 1'b1;
              start_r <= 1'b1;
            end else begin
              res_s_r <= lerp[SmpW-1:0];
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = (state_r == S_OUT);
  assign out_ch.value_first  = res_f_r;
  assign out_ch.value_second = res_s_r;
  assign out_ch.query_status = status_r;
endmodule

>>> design/altip_div.sv
// Restoring divider: quotient of (mag * t) / d, one quotient bit per cycle.
// The product is formed by shift and add, one bit of t per cycle, first.
module altip_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  altip_pkg::div_req_t    req,
  output logic                   done,
  output logic [altip_pkg::PosW:0] quot
);
  import altip_pkg::*;

  localparam int unsigned ProdW = 2 * (PosW + 1);
  localparam int unsigned CntW = $clog2(ProdW + 1);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_MUL  = 3'b010,
    D_DIV  = 3'b100
  } dstate_t;

  dstate_t          state_r;
  logic [CntW-1:0]  cnt_r;
  logic [ProdW-1:0] acc_r;
  logic [ProdW-1:0] mcand_r;
  logic [PosW:0]    mplier_r;
  logic [PosW:0]    d_r;
  logic [PosW+1:0]  rem_r;
  logic [PosW+1:0]  rem_sh;
  logic [PosW+1:0]  rem_sub;

  assign rem_sh  = {rem_r[PosW:0], acc_r[ProdW-1]};
  assign rem_sub = rem_sh - {1'b0, d_r};
  assign quot    = acc_r[PosW:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (req.start) begin
            state_r  <= D_MUL;
            acc_r    <= '0;
            mcand_r  <= {{(PosW+1){1'b0}}, req.mag};
            mplier_r <= req.t;
            d_r      <= req.d;
            cnt_r    <= CntW'(PosW + 1);
          end
        end
        D_MUL: begin
          if (mplier_r[0]) acc_r <= acc_r + mcand_r;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          cnt_r    <= cnt_r - 1'b1;
          if (cnt_r == CntW'(1)) begin
            state_r <= D_DIV;
            cnt_r   <= CntW'(ProdW);
            rem_r   <= '0;
          end
        end
        D_DIV: begin
          if (!rem_sub[PosW+1]) begin
            rem_r <= rem_sub;
            acc_r <= {acc_r[ProdW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            acc_r <= {acc_r[ProdW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CntW'(1)) begin
            state_r <= D_IDLE;
            done    <= 1'b1;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end
endmodule

>>> design/altip_mem.sv
// Knot table: one synchronous memory, write port and one registered read port.
module altip_mem #(
  parameter int unsigned MAX_KNOTS = altip_pkg::MaxKnotsDefault,
  parameter int unsigned AW = $clog2(MAX_KNOTS)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [3*altip_pkg::PosW-1:0] wdata,
  input  logic [AW-1:0]           raddr,
  output logic [3*altip_pkg::PosW-1:0] rdata
);
  import altip_pkg::*;

  logic [3*PosW-1:0] mem [MAX_KNOTS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> test/testbench.sv
module testbench;
  import altip_pkg::*;

  localparam int unsigned Knots = MaxKnotsDefault;
  localparam int unsigned ItemGoal = 1150;
  localparam int unsigned CycleLimit = 3000000;
  // Knot writes leave no result, so before a register write we let the
  // write path settle with some margin.
  localparam int unsigned SettleCycles = 16;

  typedef struct packed {
    logic signed [SmpW-1:0] first;
    logic signed [SmpW-1:0] second;
    logic [StatusW-1:0]     status;
  } lookup_t;

  // One row of the directed stimulus. When typed is set, the expected
  // lookup is given in the row; otherwise the predictor supplies it.
  typedef struct packed {
    logic              op;
    logic [SlotW-1:0]  slot;
    logic [PosW-1:0]   pos;
    logic [SmpW-1:0]   a;
    logic [SmpW-1:0]   b;
    logic              typed;
    logic [SmpW-1:0]   ea;
    logic [SmpW-1:0]   eb;
    logic [StatusW-1:0] est;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  altip_in_if in_if();
  altip_out_if out_if();

  arc_length_table_interpolator_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Shadow copy of the knot table and of the two registers.
  logic [PosW-1:0] shadow_pos [Knots];
  logic [SmpW-1:0] shadow_first [Knots];
  logic [SmpW-1:0] shadow_second [Knots];
  logic [CountW-1:0]  shadow_count;
  logic [MarginW-1:0] shadow_margin;

  lookup_t pending_lookups [$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned cycle_count;

  // Directed rows run with three knots and the reset margin of 4. Knot one
  // and two share a position; knots zero and one hold 32-bit extreme samples.
  localparam int NumRows = 14;
  row_t dir_rows [NumRows] = '{
    '{OP_WRITE, 10'd0,    32'd1000, 32'h7fffffff, 32'h80000000, 1'b0, 32'd0, 32'd0, ST_INTERP},
    '{OP_WRITE, 10'd1,    32'd2000, 32'h80000000, 32'h7fffffff, 1'b0, 32'd0, 32'd0, ST_INTERP},
    '{OP_WRITE, 10'd2,    32'd2000, 32'h00010000, 32'hffff0000, 1'b0, 32'd0, 32'd0, ST_INTERP},
    '{OP_WRITE, 10'd1023, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0, 32'd0, 32'd0,
      ST_INTERP},
    '{OP_QUERY, 10'd0, 32'd0,    32'd0, 32'd0, 1'b1, 32'h7fffffff, 32'h80000000, ST_LOW},
    '{OP_QUERY, 10'd0, 32'd996,  32'd0, 32'd0, 1'b1, 32'h7fffffff, 32'h80000000, ST_EXACT},
    '{OP_QUERY, 10'd0, 32'd1000, 32'd0, 32'd0, 1'b1, 32'h7fffffff, 32'h80000000, ST_EXACT},
    '{OP_QUERY, 10'd0, 32'd1001, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, ST_INTERP},
    '{OP_QUERY, 10'd0, 32'd1500, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, ST_INTERP},
    '{OP_QUERY, 10'd0, 32'd1999, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, ST_INTERP},
    '{OP_QUERY, 10'd0, 32'd2000, 32'd0, 32'd0, 1'b1, 32'h80000000, 32'h7fffffff, ST_EXACT},
    '{OP_QUERY, 10'd0, 32'd2004, 32'd0, 32'd0, 1'b1, 32'h00010000, 32'hffff0000, ST_HIGH},
    '{OP_QUERY, 10'd0, 32'd2005, 32'd0, 32'd0, 1'b1, 32'h00010000, 32'hffff0000, ST_HIGH},
    '{OP_QUERY, 10'd0, 32'hffffffff, 32'd0, 32'd0, 1'b1, 32'h00010000, 32'hffff0000, ST_HIGH}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Interpolate one sample, truncating the step toward zero.
  function automatic logic [SmpW-1:0] blend(logic signed [SmpW-1:0] v0,
                                            logic signed [SmpW-1:0] v1,
                                            longint unsigned t, longint unsigned d);
    longint diff;
    longint unsigned mag, q;
    diff = longint'(v1) - longint'(v0);
    mag = (diff < 0) ? longint'(-diff) : diff;
    q = (mag * t) / d;
    return (diff < 0) ? v0 - q[SmpW-1:0] : v0 + q[SmpW-1:0];
  endfunction

  // Work out the lookup for a query at position s from the shadow table.
  function automatic lookup_t lookup_at(logic [PosW-1:0] s);
    lookup_t r;
    int unsigned n, lo, hi, mid;
    longint unsigned s64, m64, t, d;
    logic [PosW-1:0] p0, p1;
    n = (shadow_count > Knots) ? Knots : shadow_count;
    s64 = s;
    m64 = shadow_margin;
    r = '{first: '0, second: '0, status: ST_EMPTY};
    if (n == 0) return r;
    if (s64 + m64 < longint'(shadow_pos[0])) begin
      return '{shadow_first[0], shadow_second[0], ST_LOW};
    end
    if (s64 > longint'(shadow_pos[n-1]) + m64) begin
      return '{shadow_first[n-1], shadow_second[n-1], ST_HIGH};
    end
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_pos[mid] < s) lo = mid + 1;
      else hi = mid;
    end
    // A query just above the last knot runs off the end of the table.
    if (lo >= n) return '{shadow_first[n-1], shadow_second[n-1], ST_HIGH};
    if (lo == 0 || shadow_pos[lo] == s) begin
      return '{shadow_first[lo], shadow_second[lo], ST_EXACT};
    end
    p0 = shadow_pos[lo-1];
    p1 = shadow_pos[lo];
    // Flat or falling segments give the lower knot unchanged.
    if (p1 <= p0 || s <= p0) return '{shadow_first[lo-1], shadow_second[lo-1], ST_INTERP};
    d = p1 - p0;
    t = s - p0;
    if (t > d) t = d;
    r.first = blend(shadow_first[lo-1], shadow_first[lo], t, d);
    r.second = blend(shadow_second[lo-1], shadow_second[lo], t, d);
    r.status = ST_INTERP;
    return r;
  endfunction

  // Offer one transaction, hold it until accepted, then update the shadow
  // table or queue the expected lookup. The sender pauses between bursts.
  task automatic send_item(logic op, logic [SlotW-1:0] slot, logic [PosW-1:0] pos,
                           logic [SmpW-1:0] a, logic [SmpW-1:0] b,
                           bit typed, lookup_t given);
    int unsigned gap;
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.knot_slot <= slot;
    in_if.arc_position <= pos;
    in_if.sample_first <= a;
    in_if.sample_second <= b;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
    if (op == OP_WRITE) begin
      shadow_pos[slot] = pos;
      shadow_first[slot] = a;
      shadow_second[slot] = b;
    end else begin
      pending_lookups.insert(pending_lookups.size(), typed ? given : lookup_at(pos));
    end
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_knot(logic [SlotW-1:0] slot, logic [PosW-1:0] pos);
    send_item(OP_WRITE, slot, pos, $urandom(), $urandom(), 1'b0, '0);
  endtask

  task automatic query_at(logic [PosW-1:0] pos);
    send_item(OP_QUERY, $urandom_range(0, Knots - 1), pos, $urandom(), $urandom(), 1'b0, '0);
  endtask

  // Registers change only with the block idle: the sender quiet, all
  // lookups back and the last knot write settled.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic reg_write(logic [CfgAddrW-1:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == AddrKnotCount) shadow_count = data[CountW-1:0];
    else if (addr == AddrEdgeMargin) shadow_margin = data[MarginW-1:0];
    @(posedge clk);
  endtask

  function automatic logic [PosW-1:0] clamp_pos(longint v);
    if (v < 0) return '0;
    if (v > longint'(32'hffffffff)) return '1;
    return v[PosW-1:0];
  endfunction

  // One phase: choose a table size and margin, fill every slot that the
  // search can reach, then query around the knots with some noise writes.
  task automatic run_phase(int unsigned count_reg, int unsigned fill, int unsigned queries);
    int unsigned mode, k, margin;
    longint acc, off;
    wait_idle();
    mode = $urandom_range(0, 9);
    margin = (mode == 0) ? 0 : (mode == 1) ? 65535 : (mode == 2) ? 4 : $urandom_range(0, 300);
    reg_write(AddrKnotCount, count_reg);
    reg_write(AddrEdgeMargin, margin);
    // Mostly rising positions with some flat steps; sometimes scrambled,
    // sometimes crowded near the top of the position range.
    acc = ($urandom_range(0, 7) == 0) ? longint'(32'hffff0000) : $urandom_range(0, 5000);
    mode = $urandom_range(0, 9);
    for (int i = 0; i < fill; i++) begin
      if (mode == 0) begin
        write_knot(i, $urandom());
      end else begin
        write_knot(i, clamp_pos(acc));
        acc += ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 1 << $urandom_range(1, 16));
      end
    end
    for (int j = 0; j < queries; j++) begin
      k = $urandom_range(0, fill - 1);
      off = longint'($urandom_range(0, 2 * margin + 40)) - longint'(margin + 20);
      case ($urandom_range(0, 9))
        0: query_at($urandom());
        1: query_at(clamp_pos(longint'(shadow_pos[0]) - margin - $urandom_range(1, 50)));
        2: query_at(clamp_pos(longint'(shadow_pos[fill-1]) + off));
        3: write_knot($urandom_range(fill, Knots - 1), $urandom());
        default: query_at(clamp_pos(longint'(shadow_pos[k]) + off));
      endcase
    end
  endtask

  // Receiver: it keeps switching at random between always-ready, coin-flip and
  // long stall windows, so stalls land on every phase of the block's work.
  int unsigned ready_mode;
  always @(posedge clk) begin
    if (cycle_count % 128 == 0) ready_mode <= $urandom_range(0, 2);
    case (ready_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= $urandom_range(0, 1);
      default: out_if.ready <= (cycle_count % 40) >= 30;
    endcase
  end

  // Compare each result transaction with the oldest expected lookup.
  always @(posedge clk) begin
    lookup_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_lookups.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h %h status %0d", $time,
                 out_if.value_first, out_if.value_second, out_if.query_status);
      end else begin
        want = pending_lookups.pop_front();
        if (out_if.value_first !== want.first) begin
          errors++;
          $display("%0t: value_first expected %h actual %h", $time, want.first,
                   out_if.value_first);
        end
        if (out_if.value_second !== want.second) begin
          errors++;
          $display("%0t: value_second expected %h actual %h", $time, want.second,
                   out_if.value_second);
        end
        if (out_if.query_status !== want.status) begin
          errors++;
          $display("%0t: query_status expected %0d actual %0d", $time, want.status,
                   out_if.query_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[arc_length_table_interpolator_core] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    items_sent = 0;
    burst_left = 0;
    shadow_count = '0;
    shadow_margin = MarginReset;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_WRITE;
    in_if.knot_slot = '0;
    in_if.arc_position = '0;
    in_if.sample_first = '0;
    in_if.sample_second = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table straight after reset.
    send_item(OP_QUERY, '0, 32'd500, '0, '0, 1'b1, '{'0, '0, ST_EMPTY});
    wait_idle();
    reg_write(AddrKnotCount, 3);
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].slot, dir_rows[i].pos, dir_rows[i].a,
                dir_rows[i].b, dir_rows[i].typed,
                '{dir_rows[i].ea, dir_rows[i].eb, dir_rows[i].est});
    end

    // Random phases, mostly small tables, a few of a single knot. Room is
    // left for the full-table phase at the end.
    while (items_sent + Knots + 40 < ItemGoal) begin
      n = ($urandom_range(0, 7) == 0) ? 1 :
          ($urandom_range(0, 5) == 0) ? $urandom_range(17, 64) : $urandom_range(2, 16);
      run_phase(n, n, $urandom_range(15, 40));
    end
    // A count above the table size saturates, so the whole table is filled.
    run_phase((1 << CountW) - 1, Knots, 40);
    wait_idle();
    reg_write(AddrKnotCount, 0);
    send_item(OP_QUERY, '1, '1, '1, '1, 1'b1, '{'0, '0, ST_EMPTY});
    in_if.valid <= 1'b0;

    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("[arc_length_table_interpolator_core] OK");
    end else begin
      $display("[arc_length_table_interpolator_core] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/altip_pkg.sv
design/altip_if.sv
design/altip_div.sv
design/altip_mem.sv
design/arc_length_table_interpolator_core.sv
test/testbench.sv
